// File: hdl/multilevel_queue_scheduler_macros.svh
// Assertion macros for the multilevel queue scheduler
`ifndef MULTILEVEL_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MLQS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset
`define MLQS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hdl/mlqs_pkg.sv
// Shared constants, types and helpers of the multilevel queue scheduler
package mlqs_pkg;

  // Queue geometry
  localparam int NUM_Q       = 7;
  localparam int QUEUE_DEPTH = 16;
  localparam int LEVEL_CAP   = 2;

  // Field widths
  localparam int ID_W    = 8;
  localparam int TYPE_W  = 2;
  localparam int LEVEL_W = 3;
  localparam int QNUM_W  = 5;
  localparam int FILL_W  = 5;
  localparam int SLICE_W = 8;
  localparam int CFG_IDX_W = 1;

  // Derived widths
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SUM_W  = CNT_W + 1;
  localparam int SLOT_W = $clog2(NUM_Q);
  localparam int RAM_DEPTH = NUM_Q * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(RAM_DEPTH);

  // Queue numbering
  localparam int SYS_BASE         = 1;
  localparam int INTER_BASE       = 10;
  localparam int LEVEL_STRIDE     = 4;
  localparam int LAST_QNUM        = 19;
  localparam int FIRST_INTER_SLOT = 3;
  localparam int LAST_SLOT        = 6;

  // Codes
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;
  localparam logic [TYPE_W-1:0] TYPE_SYSTEM      = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_INTERACTIVE = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_NORMAL      = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_BATCH       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYS_SLICE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTER_SLICE = 1'b1;

  // Reset values of the slice registers
  localparam logic [SLICE_W-1:0] SYS_SLICE_RST   = 8'd2;
  localparam logic [SLICE_W-1:0] INTER_SLICE_RST = 8'd3;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    thread_id;
    logic [TYPE_W-1:0]  thread_type;
    logic [LEVEL_W-1:0] priority_level;
  } req_t;

  typedef struct packed {
    logic [SLICE_W-1:0] sys_slice;
    logic [SLICE_W-1:0] inter_slice;
  } cfg_t;

  typedef struct packed {
    logic               accepted;
    logic               deq_hit;
    logic [QNUM_W-1:0]  queue_number;
    logic [FILL_W-1:0]  queue_fill;
    logic               slice_limited;
    logic [SLICE_W-1:0] slice_len;
  } rslt_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   wdata;
  } ram_req_t;

  // One-based queue number of a physical slot
  function automatic logic [QNUM_W-1:0] slot_number(input logic [SLOT_W-1:0] s);
    logic [QNUM_W-1:0] n;
    if (s < SLOT_W'(FIRST_INTER_SLOT)) begin
      n = QNUM_W'(SYS_BASE) + QNUM_W'(LEVEL_STRIDE) * QNUM_W'(s);
    end else if (s < SLOT_W'(LAST_SLOT)) begin
      n = QNUM_W'(INTER_BASE)
        + QNUM_W'(LEVEL_STRIDE) * QNUM_W'(s - SLOT_W'(FIRST_INTER_SLOT));
    end else begin
      n = QNUM_W'(LAST_QNUM);
    end
    return n;
  endfunction

endpackage

// File: hdl/mlqs_ram.sv
// Generic single-port RAM with registered read
module mlqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/mlqs_queue_ctrl.sv
// Queue pointers, slot selection, dequeue priority encoder and result build
module mlqs_queue_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  mlqs_pkg::req_t    req,
  input  mlqs_pkg::cfg_t    cfg,
  output mlqs_pkg::rslt_t   rslt,
  output mlqs_pkg::ram_req_t ram_req
);
  import mlqs_pkg::*;

  logic [PTR_W-1:0] heads_r  [NUM_Q];
  logic [CNT_W-1:0] counts_r [NUM_Q];

  logic [LEVEL_W-1:0] level;
  logic [SLOT_W-1:0]  enq_slot;
  logic [SLOT_W-1:0]  deq_slot;
  logic               deq_found;
  logic [SLOT_W-1:0]  sel;
  logic [PTR_W-1:0]   sel_head;
  logic [CNT_W-1:0]   sel_cnt;
  logic               not_full;
  logic [SUM_W-1:0]   tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   head_inc;
  logic               do_enq;
  logic               do_deq;

  // Level clamp and enqueue slot by type
  always_comb begin
    level = (req.priority_level > LEVEL_W'(LEVEL_CAP)) ? LEVEL_W'(LEVEL_CAP)
                                                       : req.priority_level;
    if (req.thread_type == TYPE_SYSTEM) begin
      enq_slot = SLOT_W'(level);
    end else if (req.thread_type == TYPE_INTERACTIVE) begin
      enq_slot = SLOT_W'(FIRST_INTER_SLOT) + SLOT_W'(level);
    end else begin
      enq_slot = SLOT_W'(LAST_SLOT);
    end
  end

  // First non-empty queue, highest priority at slot zero
  always_comb begin
    deq_found = 1'b0;
    deq_slot  = '0;
    for (int i = NUM_Q - 1; i >= 0; i--) begin
      if (counts_r[i] != '0) begin
        deq_found = 1'b1;
        deq_slot  = SLOT_W'(i);
      end
    end
  end

  // Selected queue state and pointer arithmetic
  always_comb begin
    sel      = (req.kind == KIND_DEQ) ? deq_slot : enq_slot;
    sel_head = heads_r[sel];
    sel_cnt  = counts_r[sel];
    not_full = sel_cnt < CNT_W'(QUEUE_DEPTH);
    tail_sum = SUM_W'(sel_head) + SUM_W'(sel_cnt);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail = PTR_W'(tail_sum);
    end
    head_inc = (sel_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + PTR_W'(1);
    do_enq   = accept && (req.kind == KIND_ENQ) && not_full;
    do_deq   = accept && (req.kind == KIND_DEQ) && deq_found;
  end

  // RAM access: write at tail or read at head
  always_comb begin
    ram_req.we    = do_enq;
    ram_req.re    = do_deq;
    ram_req.wdata = req.thread_id;
    ram_req.addr  = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH)
                  + ADDR_W'((req.kind == KIND_DEQ) ? sel_head : tail);
  end

  // Result fields
  always_comb begin
    rslt = '0;
    if (req.kind == KIND_ENQ) begin
      rslt.accepted     = not_full;
      rslt.queue_number = slot_number(sel);
      rslt.queue_fill   = FILL_W'(sel_cnt);
    end else if (deq_found) begin
      rslt.accepted     = 1'b1;
      rslt.deq_hit      = 1'b1;
      rslt.queue_number = slot_number(sel);
      rslt.queue_fill   = FILL_W'(sel_cnt);
      if (sel < SLOT_W'(FIRST_INTER_SLOT)) begin
        rslt.slice_limited = 1'b1;
        rslt.slice_len     = cfg.sys_slice;
      end else if (sel < SLOT_W'(LAST_SLOT)) begin
        rslt.slice_limited = 1'b1;
        rslt.slice_len     = cfg.inter_slice;
      end
    end
  end

  // Pointer and occupancy update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_Q; i++) begin
        heads_r[i]  <= '0;
        counts_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_Q; i++) begin
        if (sel == SLOT_W'(i)) begin
          if (do_enq) begin
            counts_r[i] <= counts_r[i] + CNT_W'(1);
          end else if (do_deq) begin
            counts_r[i] <= counts_r[i] - CNT_W'(1);
            heads_r[i]  <= head_inc;
          end
        end
      end
    end
  end

endmodule

// File: hdl/multilevel_queue_scheduler.sv
// Top level of the multilevel queue scheduler
// Seven FIFO queues of thread ids in fixed priority order (queue numbers 1, 5, 9,
// 10, 14, 18, 19). Each request item, enqueue or dequeue, once accepted, has
// its result in the output register on the following cycle,
// so one item per cycle is sustained while the output side takes results. The
// figure is set by the occupancy priority encoder and the single-port id
// store, which sees one write or one read per item. in_stall is raised during
// reset and while a result is held by out_stall. The id store has no clearing
// pass: an entry is never read before it has been written.
module multilevel_queue_scheduler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [mlqs_pkg::ID_W-1:0]        in_thread_id,
  input  logic [mlqs_pkg::TYPE_W-1:0]      in_thread_type,
  input  logic [mlqs_pkg::LEVEL_W-1:0]     in_priority_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_accepted,
  output logic [mlqs_pkg::ID_W-1:0]        out_out_thread,
  output logic [mlqs_pkg::QNUM_W-1:0]      out_queue_number,
  output logic [mlqs_pkg::FILL_W-1:0]      out_queue_fill,
  output logic                             out_slice_limited,
  output logic [mlqs_pkg::SLICE_W-1:0]     out_slice_len,
  input  logic                             cfg_we,
  input  logic [mlqs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlqs_pkg::SLICE_W-1:0]     cfg_wdata
);
  import mlqs_pkg::*;

  logic     accept;
  req_t     req;
  cfg_t     cfg_r;
  rslt_t    rslt;
  rslt_t    rslt_r;
  ram_req_t ram_req;
  logic     out_valid_r;
  logic [ID_W-1:0] ram_rdata;

  // Input handshake; held off during reset
  assign in_stall = !rst_n || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign req      = '{kind: in_kind, thread_id: in_thread_id,
                      thread_type: in_thread_type, priority_level: in_priority_level};

  // Slice registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sys_slice   <= SYS_SLICE_RST;
      cfg_r.inter_slice <= INTER_SLICE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYS_SLICE:   cfg_r.sys_slice   <= cfg_wdata;
        CFG_INTER_SLICE: cfg_r.inter_slice <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mlqs_queue_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .req     (req),
    .cfg     (cfg_r),
    .rslt    (rslt),
    .ram_req (ram_req)
  );

  mlqs_ram #(
    .WIDTH (ID_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  // Result register; the popped id comes straight from the store's read register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rslt_r <= rslt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = rslt_r.accepted;
  assign out_out_thread    = rslt_r.deq_hit ? ram_rdata : '0;
  assign out_queue_number  = rslt_r.queue_number;
  assign out_queue_fill    = rslt_r.queue_fill;
  assign out_slice_limited = rslt_r.slice_limited;
  assign out_slice_len     = rslt_r.slice_len;

  // Checks
  `include "multilevel_queue_scheduler_macros.svh"

  `MLQS_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_r, "accepted item gave no result")
  `MLQS_ASSERT_IMPL(a_last_queue_unlimited,
    out_valid_r && out_queue_number == QNUM_W'(LAST_QNUM), !out_slice_limited,
    "last queue served with a slice")
  `MLQS_ASSERT_IMPL(a_slice_needs_limit, out_valid_r && out_slice_len != '0,
    out_slice_limited, "slice length without limit flag")
  `MLQS_ASSERT_IMPL(a_hit_has_queue, out_valid_r && out_accepted,
    out_queue_number != '0, "accepted result without queue number")

endmodule
